>>> hdl/ansi_terminal_escape_parser_top_defines.svh
// Assertion macros for the escape parser RTL.
// Included by atep_ctrl, the module that carries concurrent checks; no other dependencies.
`ifndef ANSI_TERMINAL_ESCAPE_PARSER_TOP_DEFINES_SVH
`define ANSI_TERMINAL_ESCAPE_PARSER_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication under reset.
`define ATEP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication under reset.
`define ATEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ATEP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ATEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/atep_pkg.sv
// Types, byte codes and command codes of the terminal escape parser.
// Used by the interface, controller, datapath and top level.
package atep_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 256;
    localparam int MAX_PARAMS = 16;
    localparam int TAB_WIDTH  = 8;

    localparam int ROW_W   = 6;
    localparam int COL_W   = 8;
    localparam int ROWS_W  = 7;
    localparam int COLS_W  = 9;
    localparam int CFG_W   = 9;
    localparam int PARAM_W = 16;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd24;
    localparam logic [COLS_W-1:0] COLS_RESET = 9'd80;
    localparam logic [7:0]        FG_RESET   = 8'd7;

    // configuration register indexes
    localparam logic [0:0] CFG_ROWS = 1'b0;
    localparam logic [0:0] CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2,
        MODE_OSC    = 2'd3
    } t_mode;

    localparam logic [3:0] CMD_NONE        = 4'd0;
    localparam logic [3:0] CMD_WRITE       = 4'd1;
    localparam logic [3:0] CMD_SCROLL      = 4'd2;
    localparam logic [3:0] CMD_ERASE_END   = 4'd3;
    localparam logic [3:0] CMD_ERASE_START = 4'd4;
    localparam logic [3:0] CMD_CLEAR_HOME  = 4'd5;
    localparam logic [3:0] CMD_LINE_FROM   = 4'd6;
    localparam logic [3:0] CMD_LINE_TO     = 4'd7;
    localparam logic [3:0] CMD_LINE_ALL    = 4'd8;

    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [7:0] FIN_UP      = 8'h41;
    localparam logic [7:0] FIN_DOWN    = 8'h42;
    localparam logic [7:0] FIN_RIGHT   = 8'h43;
    localparam logic [7:0] FIN_LEFT    = 8'h44;
    localparam logic [7:0] FIN_POS     = 8'h48;
    localparam logic [7:0] FIN_ERASE   = 8'h4A;
    localparam logic [7:0] FIN_ERASE_L = 8'h4B;
    localparam logic [7:0] FIN_POS_ALT = 8'h66;
    localparam logic [7:0] FIN_SGR     = 8'h6D;
    localparam logic [7:0] FIN_SAVE    = 8'h73;
    localparam logic [7:0] FIN_RESTORE = 8'h75;

    localparam logic [15:0] SGR_RESET     = 16'd0;
    localparam logic [15:0] SGR_BOLD      = 16'd1;
    localparam logic [15:0] SGR_ITALIC    = 16'd3;
    localparam logic [15:0] SGR_ULINE     = 16'd4;
    localparam logic [15:0] SGR_STRIKE    = 16'd9;
    localparam logic [15:0] SGR_NO_BOLD   = 16'd22;
    localparam logic [15:0] SGR_NO_ITAL   = 16'd23;
    localparam logic [15:0] SGR_NO_ULINE  = 16'd24;
    localparam logic [15:0] SGR_NO_STRIKE = 16'd29;
    localparam logic [15:0] SGR_FG_LO     = 16'd30;
    localparam logic [15:0] SGR_FG_HI     = 16'd37;
    localparam logic [15:0] SGR_FG_EXT    = 16'd38;
    localparam logic [15:0] SGR_FG_DEF    = 16'd39;
    localparam logic [15:0] SGR_BG_LO     = 16'd40;
    localparam logic [15:0] SGR_BG_HI     = 16'd47;
    localparam logic [15:0] SGR_BG_EXT    = 16'd48;
    localparam logic [15:0] SGR_BG_DEF    = 16'd49;
    localparam logic [15:0] SGR_FGB_LO    = 16'd90;
    localparam logic [15:0] SGR_FGB_HI    = 16'd97;
    localparam logic [15:0] SGR_BGB_LO    = 16'd100;
    localparam logic [15:0] SGR_BGB_HI    = 16'd107;
    localparam logic [15:0] SGR_EXT_IDX   = 16'd5;

    typedef enum logic [2:0] {
        RD_ZERO = 3'd0,
        RD_ONE  = 3'd1,
        RD_I    = 3'd2,
        RD_I1   = 3'd3,
        RD_I2   = 3'd4
    } t_rd_src;

    typedef struct packed {
        logic    load_byte;
        logic    exec_byte;
        logic    push_final;
        logic    latch_p0;
        logic    exec_final;
        logic    sgr_start;
        logic    latch_p;
        logic    latch_p1;
        logic    sgr_eval;
        logic    out_second;
        t_rd_src rd_src;
    } t_dp_cmd;

    typedef struct packed {
        logic is_final;
        logic is_sgr_walk;
        logic sgr_last;
        logic two_results;
    } t_dp_stat;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic [3:0]       cmd;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic [6:0]       glyph;
        logic [7:0]       fore_colour;
        logic [7:0]       back_colour;
        logic [3:0]       style_bits;
        logic [ROW_W-1:0] cursor_row_now;
        logic [COL_W-1:0] cursor_col_now;
        logic             last_of_run;
    } t_result;

endpackage

>>> hdl/atep_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
// Payload types come from atep_pkg.
interface atep_chan_if #(
    parameter type T = atep_pkg::t_rx_item
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/atep_ctrl.sv
// Sequencer of the escape parser: byte intake, parameter reads, SGR walk, result drain.
// Depends on atep_pkg and the assertion macro header.
`include "ansi_terminal_escape_parser_top_defines.svh"

module atep_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    input  atep_pkg::t_dp_stat i_stat,
    output atep_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECODE = 11'b000_0000_0010,
        S_RD0    = 11'b000_0000_0100,
        S_RD1    = 11'b000_0000_1000,
        S_FINAL  = 11'b000_0001_0000,
        S_SG_R0  = 11'b000_0010_0000,
        S_SG_R1  = 11'b000_0100_0000,
        S_SG_R2  = 11'b000_1000_0000,
        S_SG_EV  = 11'b001_0000_0000,
        S_OUT1   = 11'b010_0000_0000,
        S_OUT2   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.rd_src = atep_pkg::RD_ZERO;
        o_rx_ready  = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_rx_ready = 1'b1;
                if (i_rx_valid) begin
                    o_cmd.load_byte = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_final) begin
                    o_cmd.push_final = 1'b1;
                    n_state = S_RD0;
                end else begin
                    o_cmd.exec_byte = 1'b1;
                    n_state = S_OUT1;
                end
            end
            S_RD0: begin
                o_cmd.rd_src = atep_pkg::RD_ZERO;
                n_state = S_RD1;
            end
            S_RD1: begin
                o_cmd.latch_p0 = 1'b1;
                o_cmd.rd_src = atep_pkg::RD_ONE;
                n_state = S_FINAL;
            end
            S_FINAL: begin
                o_cmd.exec_final = 1'b1;
                if (i_stat.is_sgr_walk) begin
                    o_cmd.sgr_start = 1'b1;
                    n_state = S_SG_R0;
                end else begin
                    n_state = S_OUT1;
                end
            end
            S_SG_R0: begin
                o_cmd.rd_src = atep_pkg::RD_I;
                n_state = S_SG_R1;
            end
            S_SG_R1: begin
                o_cmd.latch_p = 1'b1;
                o_cmd.rd_src = atep_pkg::RD_I1;
                n_state = S_SG_R2;
            end
            S_SG_R2: begin
                o_cmd.latch_p1 = 1'b1;
                o_cmd.rd_src = atep_pkg::RD_I2;
                n_state = S_SG_EV;
            end
            S_SG_EV: begin
                o_cmd.sgr_eval = 1'b1;
                n_state = i_stat.sgr_last ? S_OUT1 : S_SG_R0;
            end
            S_OUT1: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = i_stat.two_results ? S_OUT2 : S_IDLE;
                end
            end
            S_OUT2: begin
                o_res_valid = 1'b1;
                o_cmd.out_second = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ATEP_ASSERT_IMPLY(a_ready_excl, i_clk, i_rst_n, o_rx_ready, !o_res_valid, "ready while result pending")
    `ATEP_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, i_rst_n && i_rx_valid && o_rx_ready, r_state == S_DECODE, "accepted item not decoded")
    `ATEP_ASSERT_IMPLY(a_second_valid, i_clk, i_rst_n, r_state == S_OUT2, i_stat.two_results, "second result without two results")

endmodule

>>> hdl/atep_dp.sv
// Datapath of the escape parser: mode, parameter store, cursor, colors, results.
// Depends on atep_pkg; driven by atep_ctrl commands.
module atep_dp #(
    parameter int MAX_PARAMS = atep_pkg::MAX_PARAMS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [7:0]                  i_rx_byte,
    input  atep_pkg::t_dp_cmd           i_cmd,
    output atep_pkg::t_dp_stat          o_stat,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [atep_pkg::CFG_W-1:0]  i_cfg_data,
    output atep_pkg::t_result           o_result
);

    localparam int AW  = $clog2(MAX_PARAMS);
    localparam int CW  = $clog2(MAX_PARAMS + 1);
    localparam int IW  = $clog2(MAX_PARAMS + 3);
    localparam int PW  = atep_pkg::PARAM_W;
    localparam int RW  = atep_pkg::ROW_W;
    localparam int CLW = atep_pkg::COL_W;
    localparam int RSW = atep_pkg::ROWS_W;
    localparam int CSW = atep_pkg::COLS_W;

    function automatic logic [RW-1:0] clamp_row(input logic [16:0] v, input logic [RSW-1:0] lim);
        logic [RSW-1:0] top;
        top = lim - 1'b1;
        return (v >= 17'(lim)) ? top[RW-1:0] : v[RW-1:0];
    endfunction

    function automatic logic [CLW-1:0] clamp_col(input logic [16:0] v, input logic [CSW-1:0] lim);
        logic [CSW-1:0] top;
        top = lim - 1'b1;
        return (v >= 17'(lim)) ? top[CLW-1:0] : v[CLW-1:0];
    endfunction

    logic [7:0]        r_byte;
    atep_pkg::t_mode   r_mode, n_mode;
    logic [CW-1:0]     r_count, n_count;
    logic [PW-1:0]     r_accum, n_accum;
    logic              r_has_digit, n_has_digit;
    logic [RW-1:0]     r_row, n_row, r_srow, n_srow;
    logic [CLW-1:0]    r_col, n_col, r_scol, n_scol;
    logic [7:0]        r_fg, n_fg, r_bg, n_bg;
    logic [3:0]        r_style, n_style;
    logic [RSW-1:0]    r_rows, n_rows;
    logic [CSW-1:0]    r_cols, n_cols;
    logic [PW-1:0]     r_p0, r_p, r_p1;
    logic [IW-1:0]     r_i, n_i;
    logic              r_two, n_two;
    logic [3:0]        r_res_cmd   [2];
    logic [RW-1:0]     r_res_row   [2];
    logic [CLW-1:0]    r_res_col   [2];
    logic [6:0]        r_res_glyph [2];
    logic [3:0]        n_res_cmd   [2];
    logic [RW-1:0]     n_res_row   [2];
    logic [CLW-1:0]    n_res_col   [2];
    logic [6:0]        n_res_glyph [2];

    logic [PW-1:0]     r_store [MAX_PARAMS];
    logic [PW-1:0]     r_rd_data;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [PW-1:0]     wr_data;

    logic              is_digit;
    logic [IW-1:0]     sgr_next_i;
    logic [IW-1:0]     i_plus1, i_plus2;

    assign is_digit = (r_byte >= atep_pkg::CH_ZERO) && (r_byte <= atep_pkg::CH_NINE);
    assign i_plus1  = r_i + IW'(1);
    assign i_plus2  = r_i + IW'(2);

    always_comb begin
        case (i_cmd.rd_src)
            atep_pkg::RD_ZERO: rd_addr = '0;
            atep_pkg::RD_ONE:  rd_addr = AW'(1);
            atep_pkg::RD_I:    rd_addr = r_i[AW-1:0];
            atep_pkg::RD_I1:   rd_addr = i_plus1[AW-1:0];
            atep_pkg::RD_I2:   rd_addr = i_plus2[AW-1:0];
            default:           rd_addr = '0;
        endcase
    end

    // SGR walk step: an extended color consumes three parameters
    always_comb begin
        logic ext;
        ext = ((r_p == atep_pkg::SGR_FG_EXT) || (r_p == atep_pkg::SGR_BG_EXT))
              && (i_plus2 < IW'(r_count)) && (r_p1 == atep_pkg::SGR_EXT_IDX);
        sgr_next_i = ext ? r_i + IW'(3) : i_plus1;
    end

    assign o_stat.is_final    = (r_mode == atep_pkg::MODE_CSI) && !is_digit
                                && (r_byte != atep_pkg::CH_SEMI) && (r_byte != atep_pkg::CH_QMARK);
    assign o_stat.is_sgr_walk = (r_byte == atep_pkg::FIN_SGR) && (r_count != '0);
    assign o_stat.sgr_last    = sgr_next_i >= IW'(r_count);
    assign o_stat.two_results = r_two;

    always_comb begin
        logic [1:0]     e_n;
        logic [3:0]     e_cmd   [2];
        logic [RW-1:0]  e_row   [2];
        logic [CLW-1:0] e_col   [2];
        logic [6:0]     e_glyph [2];
        logic [RSW-1:0] row1;
        logic [CSW-1:0] col1;
        logic [9:0]     tab_next;
        logic [19:0]    acc_next;
        logic [PW-1:0]  p0e, p1e, nmov, hv, tv;
        logic [RSW-1:0] cfg_rows;
        logic [CSW-1:0] cfg_cols;

        n_mode      = r_mode;
        n_count     = r_count;
        n_accum     = r_accum;
        n_has_digit = r_has_digit;
        n_row       = r_row;
        n_col       = r_col;
        n_srow      = r_srow;
        n_scol      = r_scol;
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_style     = r_style;
        n_rows      = r_rows;
        n_cols      = r_cols;
        n_i         = r_i;
        n_two       = r_two;
        n_res_cmd   = r_res_cmd;
        n_res_row   = r_res_row;
        n_res_col   = r_res_col;
        n_res_glyph = r_res_glyph;
        wr_en       = 1'b0;
        wr_data     = r_accum;
        e_n         = 2'd0;
        e_cmd       = '{atep_pkg::CMD_NONE, atep_pkg::CMD_NONE};
        e_row       = '{'0, '0};
        e_col       = '{'0, '0};
        e_glyph     = '{'0, '0};
        row1        = RSW'(r_row) + RSW'(1);
        col1        = CSW'(r_col) + CSW'(1);
        tab_next    = (10'(r_col) / 10'(atep_pkg::TAB_WIDTH) + 10'd1)
                      * 10'(atep_pkg::TAB_WIDTH);
        acc_next    = 20'(r_accum) * 20'd10 + 20'(r_byte[3:0]);
        p0e         = (r_count != '0) ? r_p0 : '0;
        p1e         = (r_count > CW'(1)) ? r_rd_data : '0;
        nmov        = (p0e == '0) ? PW'(1) : p0e;
        hv          = (p0e != '0) ? p0e - PW'(1) : '0;
        tv          = (p1e != '0) ? p1e - PW'(1) : '0;
        cfg_rows    = i_cfg_data[RSW-1:0];
        cfg_cols    = i_cfg_data[CSW-1:0];

        if (i_cmd.exec_byte) begin
            case (r_mode)
                atep_pkg::MODE_NORMAL: begin
                    if (r_byte == atep_pkg::CH_ESC) begin
                        n_mode = atep_pkg::MODE_ESC;
                    end else if (r_byte == atep_pkg::CH_CR) begin
                        n_col = '0;
                    end else if (r_byte == atep_pkg::CH_LF) begin
                        if (row1 >= r_rows) begin
                            n_row = clamp_row(17'(row1), r_rows);
                            e_cmd[0] = atep_pkg::CMD_SCROLL;
                            e_row[0] = n_row;
                            e_col[0] = r_col;
                            e_n = 2'd1;
                        end else begin
                            n_row = row1[RW-1:0];
                        end
                    end else if (r_byte == atep_pkg::CH_TAB) begin
                        n_col = clamp_col(17'(tab_next), r_cols);
                    end else if (r_byte == atep_pkg::CH_BS) begin
                        if (r_col != '0) begin
                            n_col = r_col - 1'b1;
                        end
                    end else if ((r_byte >= atep_pkg::CH_SPACE) && (r_byte < atep_pkg::CH_DEL)) begin
                        e_cmd[0]   = atep_pkg::CMD_WRITE;
                        e_row[0]   = r_row;
                        e_col[0]   = r_col;
                        e_glyph[0] = r_byte[6:0];
                        e_n = 2'd1;
                        if (col1 >= r_cols) begin
                            // wrap to the next line, scrolling at the bottom
                            n_col = '0;
                            if (row1 >= r_rows) begin
                                n_row = clamp_row(17'(row1), r_rows);
                                e_cmd[1] = atep_pkg::CMD_SCROLL;
                                e_row[1] = n_row;
                                e_col[1] = '0;
                                e_n = 2'd2;
                            end else begin
                                n_row = row1[RW-1:0];
                            end
                        end else begin
                            n_col = col1[CLW-1:0];
                        end
                    end
                end
                atep_pkg::MODE_ESC: begin
                    if (r_byte == atep_pkg::CH_LBRACK) begin
                        n_mode      = atep_pkg::MODE_CSI;
                        n_count     = '0;
                        n_accum     = '0;
                        n_has_digit = 1'b0;
                    end else if (r_byte == atep_pkg::CH_RBRACK) begin
                        n_mode = atep_pkg::MODE_OSC;
                    end else begin
                        n_mode = atep_pkg::MODE_NORMAL;
                    end
                end
                atep_pkg::MODE_CSI: begin
                    if (is_digit) begin
                        n_accum     = (acc_next > 20'hFFFF) ? '1 : acc_next[PW-1:0];
                        n_has_digit = 1'b1;
                    end else if (r_byte == atep_pkg::CH_SEMI) begin
                        wr_data = r_has_digit ? r_accum : '0;
                        if (r_count < CW'(MAX_PARAMS)) begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                        n_accum     = '0;
                        n_has_digit = 1'b0;
                    end
                end
                atep_pkg::MODE_OSC: begin
                    if ((r_byte == atep_pkg::CH_BEL) || (r_byte == atep_pkg::CH_ESC)) begin
                        n_mode = atep_pkg::MODE_NORMAL;
                    end
                end
                default: n_mode = r_mode;
            endcase
        end

        if (i_cmd.push_final) begin
            if (r_has_digit && (r_count < CW'(MAX_PARAMS))) begin
                wr_en   = 1'b1;
                n_count = r_count + 1'b1;
            end
            n_accum     = '0;
            n_has_digit = 1'b0;
        end

        if (i_cmd.exec_final) begin
            n_mode = atep_pkg::MODE_NORMAL;
            unique case (r_byte)
                atep_pkg::FIN_POS, atep_pkg::FIN_POS_ALT: begin
                    n_row = clamp_row(17'(hv), r_rows);
                    n_col = clamp_col(17'(tv), r_cols);
                end
                atep_pkg::FIN_ERASE: begin
                    if (p0e == PW'(0)) begin
                        e_cmd[0] = atep_pkg::CMD_ERASE_END;
                        e_row[0] = r_row;
                        e_col[0] = r_col;
                        e_n = 2'd1;
                    end else if (p0e == PW'(1)) begin
                        e_cmd[0] = atep_pkg::CMD_ERASE_START;
                        e_row[0] = r_row;
                        e_col[0] = r_col;
                        e_n = 2'd1;
                    end else if (p0e == PW'(2)) begin
                        n_row = '0;
                        n_col = '0;
                        e_cmd[0] = atep_pkg::CMD_CLEAR_HOME;
                        e_n = 2'd1;
                    end
                end
                atep_pkg::FIN_ERASE_L: begin
                    e_row[0] = r_row;
                    e_col[0] = r_col;
                    if (p0e == PW'(0)) begin
                        e_cmd[0] = atep_pkg::CMD_LINE_FROM;
                        e_n = 2'd1;
                    end else if (p0e == PW'(1)) begin
                        e_cmd[0] = atep_pkg::CMD_LINE_TO;
                        e_n = 2'd1;
                    end else if (p0e == PW'(2)) begin
                        e_cmd[0] = atep_pkg::CMD_LINE_ALL;
                        e_n = 2'd1;
                    end
                end
                atep_pkg::FIN_SGR: begin
                    if (r_count == '0) begin
                        n_style = '0;
                        n_fg    = atep_pkg::FG_RESET;
                        n_bg    = '0;
                    end
                end
                atep_pkg::FIN_UP: begin
                    n_row = (nmov >= PW'(r_row)) ? '0 : r_row - nmov[RW-1:0];
                end
                atep_pkg::FIN_DOWN: begin
                    n_row = clamp_row(17'(r_row) + 17'(nmov), r_rows);
                end
                atep_pkg::FIN_RIGHT: begin
                    n_col = clamp_col(17'(r_col) + 17'(nmov), r_cols);
                end
                atep_pkg::FIN_LEFT: begin
                    n_col = (nmov >= PW'(r_col)) ? '0 : r_col - nmov[CLW-1:0];
                end
                atep_pkg::FIN_SAVE: begin
                    n_srow = r_row;
                    n_scol = r_col;
                end
                atep_pkg::FIN_RESTORE: begin
                    n_row = clamp_row(17'(r_srow), r_rows);
                    n_col = clamp_col(17'(r_scol), r_cols);
                end
                default: n_mode = atep_pkg::MODE_NORMAL;
            endcase
        end

        if (i_cmd.exec_byte || i_cmd.exec_final) begin
            if (e_n == 2'd0) begin
                e_cmd[0] = atep_pkg::CMD_NONE;
                e_row[0] = n_row;
                e_col[0] = n_col;
            end
            n_res_cmd   = e_cmd;
            n_res_row   = e_row;
            n_res_col   = e_col;
            n_res_glyph = e_glyph;
            n_two       = (e_n == 2'd2);
        end

        if (i_cmd.sgr_start) begin
            n_i = '0;
        end

        if (i_cmd.sgr_eval) begin
            n_i = sgr_next_i;
            unique case (r_p) inside
                atep_pkg::SGR_RESET: begin
                    n_style = '0;
                    n_fg    = atep_pkg::FG_RESET;
                    n_bg    = '0;
                end
                atep_pkg::SGR_BOLD:      n_style = r_style | 4'b0001;
                atep_pkg::SGR_ITALIC:    n_style = r_style | 4'b0010;
                atep_pkg::SGR_ULINE:     n_style = r_style | 4'b0100;
                atep_pkg::SGR_STRIKE:    n_style = r_style | 4'b1000;
                atep_pkg::SGR_NO_BOLD:   n_style = r_style & 4'b1110;
                atep_pkg::SGR_NO_ITAL:   n_style = r_style & 4'b1101;
                atep_pkg::SGR_NO_ULINE:  n_style = r_style & 4'b1011;
                atep_pkg::SGR_NO_STRIKE: n_style = r_style & 4'b0111;
                [atep_pkg::SGR_FG_LO:atep_pkg::SGR_FG_HI]: n_fg = r_p[7:0] - 8'd30;
                atep_pkg::SGR_FG_EXT: begin
                    if (sgr_next_i != i_plus1) begin
                        n_fg = r_rd_data[7:0];
                    end
                end
                atep_pkg::SGR_FG_DEF: n_fg = atep_pkg::FG_RESET;
                [atep_pkg::SGR_BG_LO:atep_pkg::SGR_BG_HI]: n_bg = r_p[7:0] - 8'd40;
                atep_pkg::SGR_BG_EXT: begin
                    if (sgr_next_i != i_plus1) begin
                        n_bg = r_rd_data[7:0];
                    end
                end
                atep_pkg::SGR_BG_DEF: n_bg = '0;
                [atep_pkg::SGR_FGB_LO:atep_pkg::SGR_FGB_HI]: n_fg = r_p[7:0] - 8'd82;
                [atep_pkg::SGR_BGB_LO:atep_pkg::SGR_BGB_HI]: n_bg = r_p[7:0] - 8'd92;
                default: n_style = r_style;
            endcase
        end

        // register writes clamp the value and pull the cursor onto the screen
        if (i_cfg_we) begin
            if (i_cfg_idx == atep_pkg::CFG_ROWS) begin
                if (cfg_rows == '0) begin
                    cfg_rows = RSW'(1);
                end else if (cfg_rows > RSW'(atep_pkg::MAX_ROWS)) begin
                    cfg_rows = RSW'(atep_pkg::MAX_ROWS);
                end
                n_rows = cfg_rows;
                n_row  = clamp_row(17'(r_row), cfg_rows);
            end else begin
                if (cfg_cols == '0) begin
                    cfg_cols = CSW'(1);
                end else if (cfg_cols > CSW'(atep_pkg::MAX_COLS)) begin
                    cfg_cols = CSW'(atep_pkg::MAX_COLS);
                end
                n_cols = cfg_cols;
                n_col  = clamp_col(17'(r_col), cfg_cols);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_count[AW-1:0]] <= wr_data;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.latch_p0) begin
            r_p0 <= r_rd_data;
        end
        if (i_cmd.latch_p) begin
            r_p <= r_rd_data;
        end
        if (i_cmd.latch_p1) begin
            r_p1 <= r_rd_data;
        end
        r_i         <= n_i;
        r_two       <= n_two;
        r_res_cmd   <= n_res_cmd;
        r_res_row   <= n_res_row;
        r_res_col   <= n_res_col;
        r_res_glyph <= n_res_glyph;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= atep_pkg::MODE_NORMAL;
            r_count     <= '0;
            r_accum     <= '0;
            r_has_digit <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_srow      <= '0;
            r_scol      <= '0;
            r_fg        <= atep_pkg::FG_RESET;
            r_bg        <= '0;
            r_style     <= '0;
            r_rows      <= atep_pkg::ROWS_RESET;
            r_cols      <= atep_pkg::COLS_RESET;
        end else begin
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_accum     <= n_accum;
            r_has_digit <= n_has_digit;
            r_row       <= n_row;
            r_col       <= n_col;
            r_srow      <= n_srow;
            r_scol      <= n_scol;
            r_fg        <= n_fg;
            r_bg        <= n_bg;
            r_style     <= n_style;
            r_rows      <= n_rows;
            r_cols      <= n_cols;
        end
    end

    always_comb begin
        logic sel;
        sel = i_cmd.out_second;
        o_result.cmd            = r_res_cmd[sel];
        o_result.cell_row       = r_res_row[sel];
        o_result.cell_col       = r_res_col[sel];
        o_result.glyph          = r_res_glyph[sel];
        o_result.fore_colour    = r_fg;
        o_result.back_colour    = r_bg;
        o_result.style_bits     = r_style;
        o_result.cursor_row_now = r_row;
        o_result.cursor_col_now = r_col;
        o_result.last_of_run    = sel | ~r_two;
    end

endmodule

>>> hdl/ansi_terminal_escape_parser_top.sv
// Top level of the terminal escape parser: controller plus datapath.
// Depends on atep_pkg, atep_chan_if, atep_ctrl and atep_dp.
//
//   channel  direction  payload         handshake
//   i_rx     in         rx_byte         valid/ready
//   o_res    out        t_result item   valid/ready
//   i_cfg_*  in         rows / cols     write enable, no wait
//
// Ordinary bytes pass through accept, decode and a result state (two if a wrap scrolls).
// A CSI final byte adds parameter reads (S_RD0, S_RD1, S_FINAL) through the single store read port.
// An SGR final walks the store through S_SG_R0, S_SG_R1, S_SG_R2, S_SG_EV per parameter (extended colors count once).
// Reset is synchronous, active low; the parameter store has no reset or clearing pass.
// A stalled result holds the block; no new item is taken until all results drain.
module ansi_terminal_escape_parser_top #(
    parameter int MAX_PARAMS = atep_pkg::MAX_PARAMS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    atep_chan_if.sink                  i_rx,
    atep_chan_if.source                o_res,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [atep_pkg::CFG_W-1:0] i_cfg_data
);

    atep_pkg::t_dp_cmd  dp_cmd;
    atep_pkg::t_dp_stat dp_stat;
    atep_pkg::t_result  result;
    logic               rx_ready;
    logic               res_valid;

    atep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx.valid),
        .o_rx_ready  (rx_ready),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    atep_dp #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_byte  (i_rx.data.rx_byte),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    assign i_rx.ready  = rx_ready;
    assign o_res.valid = res_valid;
    assign o_res.data  = result;

endmodule
